FILE: hw/rtl/sle_pkg.sv
// sle_pkg: shared types, field widths, mode and status codes of the list engine
// no dependencies; compiled first

package sle_pkg;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;

    localparam int CAPACITY_DEF = 16;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 5'd16;

    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [POS_W-1:0]          t_pos;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STAT_W-1:0]         t_status;
    typedef logic [LEN_W-1:0]          t_len;

    localparam t_mode MODE_SEARCH = 3'd0;
    localparam t_mode MODE_READ   = 3'd1;
    localparam t_mode MODE_APPEND = 3'd2;
    localparam t_mode MODE_DELETE = 3'd3;
    localparam t_mode MODE_MODIFY = 3'd4;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_BADPOS = 2'd2;
    localparam t_status ST_FULL   = 2'd3;

    // per-cycle control broadcast along the row of cells
    typedef struct packed {
        logic rotate;  // every cell takes its right neighbour's entry
        logic del_en;  // cells at or above the delete index take their neighbour's entry
    } t_cell_ctl;

endpackage

FILE: hw/rtl/sle_req_if.sv
// sle_req_if: request channel of the list engine (valid/ready plus request fields)
// depends on sle_pkg

interface sle_req_if;
    logic               valid;
    logic               ready;
    sle_pkg::t_mode     mode;
    sle_pkg::t_pos      position;
    sle_pkg::t_value    value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

FILE: hw/rtl/sle_rsp_if.sv
// sle_rsp_if: result channel of the list engine (valid/ready plus result fields)
// depends on sle_pkg

interface sle_rsp_if;
    logic               valid;
    logic               ready;
    sle_pkg::t_status   status;
    sle_pkg::t_len      found_position;
    sle_pkg::t_value    read_value;
    sle_pkg::t_len      list_length;

    modport source (output valid, output status, output found_position,
                    output read_value, output list_length, input ready);
    modport sink   (input valid, input status, input found_position,
                    input read_value, input list_length, output ready);
endinterface

FILE: hw/rtl/sequential_list_engine.sv
// sequential_list_engine: ordered list of signed entries kept in a row of cells
// depends on sle_pkg, sle_req_if, sle_rsp_if and sle_cell
//
//   channel    dir  handshake      payload
//   i_req      in   valid/ready    mode, position, value
//   o_rsp      out  valid/ready    status, found_position, read_value, list_length
//   cfg        in   i_cfg_we       i_cfg_wdata (max_length)
//
// search, read, append and modify rotate the ring of CAPACITY cells once, one
// entry past cell 0 per cycle, and then register the result once the output is free.
// delete shifts the upper cells down in the accept cycle; it and every rejected
// or unused request skip the rotation and register the result. one item in work.
// reset empties the list and sets max_length to 16; the entries are not cleared.
// a stalled result is held in the output register while the next item is taken.

module sequential_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sle_req_if.sink             i_req,
    sle_rsp_if.source           o_rsp,
    input  logic                i_cfg_we,
    input  sle_pkg::t_len       i_cfg_wdata
);
    import sle_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    localparam logic [CW-1:0] STEP_END = CW'(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_PUT    = 2'd3;

    logic            r_state,   n_state;
    logic [CW-1:0]   r_step,    n_step;
    logic [CW-1:0]   r_count,   n_count;
    t_len            r_max_len, n_max_len;
    logic [1:0]      r_act,     n_act;
    logic [IW-1:0]   r_tgt,     n_tgt;
    t_value          r_val,     n_val;
    t_status         r_status,  n_status;
    t_len            r_found,   n_found;
    t_value          r_rd,      n_rd;
    logic            r_ovalid,  n_ovalid;
    t_status         r_o_status, n_o_status;
    t_len            r_o_found,  n_o_found;
    t_value          r_o_rd,     n_o_rd;
    t_len            r_o_len,    n_o_len;

    logic            w_acc;
    logic            w_empty;
    logic            w_badpos;
    logic            w_full;
    logic [EW-1:0]   w_cnt_e;
    logic [EW-1:0]   w_pos_e;
    logic [EW-1:0]   w_pm1;
    logic [EW-1:0]   w_step_p1;
    logic [IW-1:0]   w_pos_idx;
    logic [IW-1:0]   w_step_idx;
    logic            w_rot;
    logic            w_del;
    logic            w_finish;
    t_value          w_tail;
    t_cell_ctl       w_ctl;
    t_value          w_data [CAPACITY];

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid & i_req.ready;

    assign w_cnt_e   = EW'(r_count);
    assign w_pos_e   = EW'(i_req.position);
    assign w_pm1     = w_pos_e - EW'(1);
    assign w_pos_idx = w_pm1[IW-1:0];
    assign w_empty   = (r_count == '0);
    assign w_badpos  = (w_pos_e == '0) || (w_pos_e > w_cnt_e);
    assign w_full    = (w_cnt_e >= EW'(r_max_len)) || (r_count == STEP_END);

    assign w_step_idx = r_step[IW-1:0];
    assign w_step_p1  = EW'(r_step) + EW'(1);
    assign w_rot      = (r_state == ST_RUN) && (r_step != STEP_END);
    assign w_del      = w_acc && (i_req.mode == MODE_DELETE) && !w_empty && !w_badpos;
    assign w_finish   = (r_state == ST_RUN) && (r_step == STEP_END)
                        && (!r_ovalid || o_rsp.ready);

    // the entry leaving cell 0 re-enters at the tail, replaced at the write slot
    assign w_tail = ((r_act == ACT_PUT) && (w_step_idx == r_tgt)) ? r_val : w_data[0];

    assign w_ctl.rotate = w_rot;
    assign w_ctl.del_en = w_del;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value w_next;
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_tail;
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        sle_cell #(
            .IDX_W (IW),
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_del_idx (w_pos_idx),
            .i_next    (w_next),
            .o_data    (w_data[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_count    = r_count;
        n_max_len  = r_max_len;
        n_act      = r_act;
        n_tgt      = r_tgt;
        n_val      = r_val;
        n_status   = r_status;
        n_found    = r_found;
        n_rd       = r_rd;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_rd     = r_o_rd;
        n_o_len    = r_o_len;

        if (i_cfg_we) begin
            n_max_len = i_cfg_wdata;
        end

        if (o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        if (w_acc) begin
            n_state  = ST_RUN;
            n_step   = STEP_END;
            n_act    = ACT_NONE;
            n_tgt    = w_pos_idx;
            n_val    = i_req.value;
            n_status = ST_OK;
            n_found  = '0;
            n_rd     = '0;
            case (i_req.mode)
                MODE_SEARCH: begin
                    n_status = ST_EMPTY;
                    n_act    = ACT_SEARCH;
                    n_step   = '0;
                end
                MODE_READ, MODE_MODIFY: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else if (w_badpos) begin
                        n_status = ST_BADPOS;
                    end else begin
                        n_act  = (i_req.mode == MODE_READ) ? ACT_READ : ACT_PUT;
                        n_step = '0;
                    end
                end
                MODE_APPEND: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_act   = ACT_PUT;
                        n_tgt   = r_count[IW-1:0];
                        n_step  = '0;
                        n_count = r_count + CW'(1);
                    end
                end
                MODE_DELETE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else if (w_badpos) begin
                        n_status = ST_BADPOS;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_rot) begin
            n_step = r_step + CW'(1);
            // first match only, and only below the length
            if ((r_act == ACT_SEARCH) && (r_status != ST_OK) && (r_step < r_count)
                && (w_data[0] == r_val)) begin
                n_status = ST_OK;
                n_found  = w_step_p1[LEN_W-1:0];
            end
            if ((r_act == ACT_READ) && (w_step_idx == r_tgt)) begin
                n_rd = w_data[0];
            end
        end

        if (w_finish) begin
            n_state    = ST_IDLE;
            n_ovalid   = 1'b1;
            n_o_status = r_status;
            n_o_found  = r_found;
            n_o_rd     = r_rd;
            n_o_len    = LEN_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= STEP_END;
            r_count   <= '0;
            r_max_len <= MAX_LEN_RST;
            r_act     <= ACT_NONE;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_count   <= n_count;
            r_max_len <= n_max_len;
            r_act     <= n_act;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt      <= n_tgt;
        r_val      <= n_val;
        r_status   <= n_status;
        r_found    <= n_found;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_rd     <= n_o_rd;
        r_o_len    <= n_o_len;
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.found_position = r_o_found;
    assign o_rsp.read_value     = r_o_rd;
    assign o_rsp.list_length    = r_o_len;

endmodule

FILE: hw/rtl/sle_cell.sv
// sle_cell: one list slot, holds a single entry and loads its neighbour's entry
// on rotate or on a delete shift at or above the delete index; depends on sle_pkg

module sle_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic               i_clk,
    input  sle_pkg::t_cell_ctl i_ctl,
    input  logic [IDX_W-1:0]   i_del_idx,
    input  sle_pkg::t_value    i_next,
    output sle_pkg::t_value    o_data
);
    import sle_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    t_value r_data;
    logic   w_shift;

    assign w_shift = i_ctl.rotate | (i_ctl.del_en & (MY_IDX >= i_del_idx));

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

FILE: tb/sv/tb_sle_checker.sv
`timescale 1ns / 100ps
// tb_sle_checker: watches the request, result and register ports of the list engine,
// keeps its own copy of the list, and compares every result against the oldest expected one
// depends on sle_pkg, sle_req_if and sle_rsp_if

module tb_sle_checker #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sle_req_if            i_req,
    sle_rsp_if            i_rsp,
    input  logic          i_cfg_we,
    input  sle_pkg::t_len i_cfg_wdata,
    output int            o_fail_count,
    output int            o_pending,
    output sle_pkg::t_len o_list_len,
    output int            o_status_seen [4]
);
    import sle_pkg::*;

    typedef struct packed {
        t_status status;
        t_len    found_position;
        t_value  read_value;
        t_len    list_length;
    } t_list_reply;

    t_value      entries [CAPACITY];
    int unsigned n_entries;
    t_len        max_len;
    t_list_reply reply_q [$];
    int          fails;
    int          seen [4];

    // applies one request to the shadow list and returns the reply it should give
    function automatic t_list_reply apply_request(t_mode mode, t_pos pos, t_value val);
        t_list_reply r;
        int          i;
        int unsigned lim;
        r = '0;
        case (mode)
            MODE_SEARCH: begin
                r.status = ST_EMPTY;
                // walk down so the lowest matching slot wins
                for (i = int'(n_entries) - 1; i >= 0; i--) begin
                    if (entries[i] == val) begin
                        r.status         = ST_OK;
                        r.found_position = t_len'(i + 1);
                    end
                end
            end
            MODE_READ, MODE_DELETE, MODE_MODIFY: begin
                if (n_entries == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos == 0 || pos > n_entries) begin
                    r.status = ST_BADPOS;
                end else if (mode == MODE_READ) begin
                    r.read_value = entries[pos - 1];
                end else if (mode == MODE_DELETE) begin
                    for (i = int'(pos); i < int'(n_entries); i++)
                        entries[i - 1] = entries[i];
                    n_entries--;
                end else begin
                    entries[pos - 1] = val;
                end
            end
            MODE_APPEND: begin
                lim = (max_len > CAPACITY) ? CAPACITY : max_len;
                if (n_entries >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    entries[n_entries] = val;
                    n_entries++;
                end
            end
            default: ;  // unused codes leave the list alone
        endcase
        r.list_length = t_len'(n_entries);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_reply want;
        t_list_reply got;
        if (!i_rst_n) begin
            n_entries = 0;
            max_len   = MAX_LEN_RST;
            reply_q.delete();
        end else begin
            // results first: a result never belongs to a request taken in the same cycle
            if (i_rsp.valid && i_rsp.ready) begin
                got.status         = i_rsp.status;
                got.found_position = i_rsp.found_position;
                got.read_value     = i_rsp.read_value;
                got.list_length    = i_rsp.list_length;
                if (reply_q.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d pos %0d value %0d len %0d",
                             $time, got.status, got.found_position, got.read_value,
                             got.list_length);
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected status %0d pos %0d value %0d len %0d",
                                 $time, want.status, want.found_position, want.read_value,
                                 want.list_length);
                        $display("%0t:          actual   status %0d pos %0d value %0d len %0d",
                                 $time, got.status, got.found_position, got.read_value,
                                 got.list_length);
                        fails++;
                    end
                    seen[want.status]++;
                end
            end
            if (i_req.valid && i_req.ready)
                reply_q.push_back(apply_request(i_req.mode, i_req.position, i_req.value));
            if (i_cfg_we)
                max_len = i_cfg_wdata;
        end
        o_fail_count  <= fails;
        o_pending     <= reply_q.size();
        o_list_len    <= t_len'(n_entries);
        o_status_seen <= seen;
    end

endmodule

FILE: tb/sv/tb_sequential_list_engine.sv
`timescale 1ns / 100ps
// tb_sequential_list_engine: clock, reset and stimulus for the list engine, plus the verdict
// depends on sle_pkg, sle_req_if, sle_rsp_if, sequential_list_engine and tb_sle_checker

module tb_sequential_list_engine;
    import sle_pkg::*;

    localparam int N_PHASES       = 8;
    localparam int ITEMS_PER_PHASE = 153;
    localparam int IDLE_PCT       = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 2 * (CAPACITY_DEF + 1);
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_len cfg_wdata;

    sle_req_if req_ch ();
    sle_rsp_if rsp_ch ();

    int   fail_count;
    int   pending;
    t_len list_len;
    int   status_seen [4];

    bit          tx_steady;
    bit          rx_steady;
    bit          rx_hold_req;
    bit          rx_hold_done;
    int unsigned quiet_cycles;
    int          sent_count;

    // a small pool so that searches hit and duplicates appear
    t_value value_pool [8] = '{32'sh0000_0000, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                               32'sd1, 32'sd42, -32'sd42, 32'sh5A5A_5A5A};

    // limit and append share per phase: grows, caps, empties and lowers below the length
    t_len        phase_limit  [N_PHASES] = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd31, 5'd8};
    int unsigned phase_append [N_PHASES] = '{45, 40, 30, 35, 10, 40, 45, 20};

    sequential_list_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    tb_sle_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_list_len    (list_len),
        .o_status_seen (status_seen)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random stalls, a stall-free stretch, and one long hold-off
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req && !rx_hold_done) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_done = 1'b1;
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(t_mode mode, t_pos pos, t_value val);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    // lets every expected result arrive, then lets the engine settle
    task automatic drain_list();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(t_len lim);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random(int unsigned append_pct);
        int unsigned pick;
        t_mode       mode;
        t_pos        pos;
        t_value      val;
        pick = $urandom_range(99);
        // positions mostly inside the list, now and then one past the tail
        pos  = t_pos'($urandom_range(int'(list_len) + 1, 1));
        val  = ($urandom_range(3) == 0) ? t_value'($urandom) : value_pool[$urandom_range(7)];
        if (pick < 10) begin
            mode = t_mode'($urandom_range(7));
            pos  = t_pos'($urandom_range(31));
            val  = t_value'($urandom);
        end else if (pick < 10 + append_pct) begin
            mode = MODE_APPEND;
        end else begin
            case ($urandom_range(3))
                0:       mode = MODE_SEARCH;
                1:       mode = MODE_READ;
                2:       mode = MODE_DELETE;
                default: mode = MODE_MODIFY;
            endcase
        end
        send_request(mode, pos, val);
    endtask

    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= MODE_SEARCH;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operations on the empty list
        send_request(MODE_SEARCH, 5'd0, 32'sd0);
        send_request(MODE_READ,   5'd1, 32'sd0);
        send_request(MODE_DELETE, 5'd1, 32'sd0);
        send_request(MODE_MODIFY, 5'd1, 32'sd1);
        // extremes and a duplicate
        send_request(MODE_APPEND, 5'd0,  32'sh7FFF_FFFF);
        send_request(MODE_APPEND, 5'd31, 32'sh8000_0000);
        send_request(MODE_APPEND, 5'd0,  32'sd7);
        send_request(MODE_APPEND, 5'd0,  32'sd7);
        send_request(MODE_APPEND, 5'd0,  -32'sd1);
        send_request(MODE_SEARCH, 5'd0,  32'sd7);
        send_request(MODE_SEARCH, 5'd0,  32'sh8000_0000);
        send_request(MODE_SEARCH, 5'd0,  32'sd12345);
        // position zero, one past the tail, top of the field, last entry
        send_request(MODE_READ,   5'd0,  32'sd0);
        send_request(MODE_READ,   5'd6,  32'sd0);
        send_request(MODE_READ,   5'd31, 32'sd0);
        send_request(MODE_READ,   5'd5,  32'sd0);
        send_request(MODE_MODIFY, 5'd1,  32'sd0);
        send_request(MODE_MODIFY, 5'd5,  32'sh5555_5555);
        send_request(MODE_DELETE, 5'd1,  32'sd0);
        send_request(MODE_DELETE, 5'd4,  32'sd0);
        send_request(MODE_SEARCH, 5'd0,  32'sh5555_5555);
        // unused codes
        send_request(t_mode'(5), 5'd16, 32'shAAAA_AAAA);
        send_request(t_mode'(6), 5'd1,  32'sd0);
        send_request(t_mode'(7), 5'd31, -32'sd1);
        drain_list();
        // limit below the present length: append is refused
        write_max_len(5'd2);
        send_request(MODE_APPEND, 5'd0, 32'sd99);
        drain_list();

        for (int p = 0; p < N_PHASES; p++) begin
            write_max_len(phase_limit[p]);
            tx_steady   = (p == 2);
            rx_steady   = (p == 2);
            rx_hold_req = (p == 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random(phase_append[p]);
            drain_list();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        $display("%0d requests over %0d limit settings, incl. a %0d-cycle result hold-off",
                 sent_count, N_PHASES + 2, HOLD_CYCLES);
        $display("results: %0d ok, %0d empty or not found, %0d bad position, %0d full",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BADPOS],
                 status_seen[ST_FULL]);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
